>>> hdl/mcds_pkg.sv
// shared types, constants and calendar tables for the month calendar day sequencer
package mcds_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int ROW_W   = 3;
    localparam int H_W     = 15;
    localparam int QUOT_W  = 7;

    // range limits of a request
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

    // calendar reform of september 1752
    localparam logic [YEAR_W-1:0]  REFORM_YEAR          = 14'd1752;
    localparam logic [MONTH_W-1:0] REFORM_MONTH         = 4'd9;
    localparam logic [DAY_W-1:0]   REFORM_LAST_OLD_DAY  = 5'd2;
    localparam logic [DAY_W:0]     REFORM_FIRST_NEW_DAY = 6'd14;

    // divide by 100 as multiply by reciprocal, exact for years below 10000
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [H_W-1:0]    JULIAN_TERM = 15'd5;
    localparam logic [WDAY_W-1:0] SATURDAY    = 3'd6;
    localparam logic [DAY_W-1:0]  LEAP_FEB    = 5'd29;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_WDAY,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_en;
        logic sum_en;
        logic init;
        logic step;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last;
    } t_dp_stat;

    // days in a non-leap month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                   len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // zeller month term floor(13 * (q + 1) / 5), jan and feb as months 13 and 14
    function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        unique case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            default: t = 6'd33;
        endcase
        return t;
    endfunction

endpackage

>>> hdl/mcds_ctrl.sv
// controller state machine: request setup sequence and day emission handshake
module mcds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mcds_pkg::t_dp_cmd  o_cmd,
    input  mcds_pkg::t_dp_stat i_stat
);
    import mcds_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = ST_WDAY;
            end
            ST_WDAY: begin
                o_cmd.init = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mcds_dp.sv
// datapath: range checks, zeller weekday of the 1st, month length and day counters
module mcds_dp (
    input  logic                          i_clk,
    input  logic [mcds_pkg::YEAR_W-1:0]   i_year,
    input  logic [mcds_pkg::MONTH_W-1:0]  i_month,
    input  mcds_pkg::t_dp_cmd             i_cmd,
    output mcds_pkg::t_dp_stat            o_stat,
    output logic [mcds_pkg::DAY_W-1:0]    o_day,
    output logic [mcds_pkg::WDAY_W-1:0]   o_wday,
    output logic [mcds_pkg::ROW_W-1:0]    o_row,
    output logic                          o_bad
);
    import mcds_pkg::*;

    logic [YEAR_W-1:0]  r_year;
    logic [YEAR_W-1:0]  r_yadj;
    logic [MONTH_W-1:0] r_month;
    logic               r_bad;
    logic               r_julian;
    logic               r_reform;
    logic [QUOT_W-1:0]  r_qa;
    logic [QUOT_W-1:0]  r_qy;
    logic [H_W-1:0]     r_h;
    logic [DAY_W-1:0]   r_month_days;
    logic [DAY_W-1:0]   r_day;
    logic [WDAY_W-1:0]  r_wday;
    logic [ROW_W-1:0]   r_row;

    logic               w_bad;
    logic               w_julian;
    logic [26:0]        w_prod_a;
    logic [26:0]        w_prod_y;
    logic [H_W-1:0]     w_h;
    logic [YEAR_W-1:0]  w_rem100;
    logic               w_leap;
    logic [5:0]         w_fold1;
    logic [3:0]         w_fold2;
    logic [2:0]         w_hmod;
    logic [WDAY_W-1:0]  w_first;
    logic [DAY_W:0]     w_next;
    logic               w_final;

    // request checks at accept
    assign w_bad = (i_year == '0) || (i_year > YEAR_MAX) ||
                   (i_month == '0) || (i_month > MONTH_MAX);
    assign w_julian = (i_year < REFORM_YEAR) ||
                      ((i_year == REFORM_YEAR) && (i_month <= REFORM_MONTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year   <= i_year;
            r_month  <= i_month;
            r_bad    <= w_bad;
            r_julian <= w_julian;
            r_reform <= (i_year == REFORM_YEAR) && (i_month == REFORM_MONTH);
            r_yadj   <= (i_month <= MONTH_FEB) ? i_year - 14'd1 : i_year;
        end
    end

    // divide adjusted year and plain year by 100
    assign w_prod_a = {13'd0, r_yadj} * {14'd0, RECIP_100};
    assign w_prod_y = {13'd0, r_year} * {14'd0, RECIP_100};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_en) begin
            r_qa <= w_prod_a[RECIP_SHIFT +: QUOT_W];
            r_qy <= w_prod_y[RECIP_SHIFT +: QUOT_W];
        end
    end

    // zeller sum before mod 7; y + y/4 always covers y/100
    assign w_h = H_W'(1) + H_W'(zeller_term(r_month)) + H_W'(r_yadj) +
                 H_W'(r_yadj >> 2) +
                 (r_julian ? JULIAN_TERM : H_W'(r_qa >> 2)) -
                 (r_julian ? H_W'(0) : H_W'(r_qa));

    // leap rule, year/400 divisible means year/100 divisible by 4
    assign w_rem100 = r_year - ({7'd0, r_qy} * 14'd100);
    assign w_leap   = (r_year[1:0] == 2'b00) &&
                      (r_julian || (w_rem100 != '0) || (r_qy[1:0] == 2'b00));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_h          <= w_h;
            r_month_days <= ((r_month == MONTH_FEB) && w_leap) ? LEAP_FEB
                                                                : month_len(r_month);
        end
    end

    // mod 7 by folding octal digits, since 8 is 1 mod 7
    assign w_fold1 = 6'(r_h[2:0]) + 6'(r_h[5:3]) + 6'(r_h[8:6]) +
                     6'(r_h[11:9]) + 6'(r_h[14:12]);
    assign w_fold2 = 4'(w_fold1[2:0]) + 4'(w_fold1[5:3]);
    assign w_hmod  = (w_fold2 >= 4'd7) ? 3'(w_fold2 - 4'd7) : w_fold2[2:0];
    // zeller 0 is saturday
    assign w_first = (w_hmod == 3'd0) ? SATURDAY : w_hmod - 3'd1;

    // next day, with the reform gap
    assign w_next  = (r_reform && (r_day == REFORM_LAST_OLD_DAY)) ? REFORM_FIRST_NEW_DAY
                                                                  : {1'b0, r_day} + 6'd1;
    assign w_final = r_bad || (w_next > {1'b0, r_month_days});

    // day, weekday and row counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_day  <= r_bad ? DAY_W'(0) : DAY_W'(1);
            r_wday <= r_bad ? WDAY_W'(0) : w_first;
            r_row  <= '0;
        end else if (i_cmd.step) begin
            r_day <= w_next[DAY_W-1:0];
            if (r_wday == SATURDAY) begin
                r_wday <= '0;
                r_row  <= r_row + ROW_W'(1);
            end else begin
                r_wday <= r_wday + WDAY_W'(1);
            end
        end
    end

    assign o_stat.last = w_final;
    assign o_day       = r_day;
    assign o_wday      = r_wday;
    assign o_row       = r_row;
    assign o_bad       = r_bad;

endmodule

>>> hdl/month_calendar_day_sequencer.sv
// top level of the month calendar day sequencer
// Takes one request (year, month) and streams one transfer per calendar day of
// that month: day number, weekday (0 Sunday .. 6 Saturday) and display row,
// with tlast on the final day. Julian rules hold through September 1752 and
// Gregorian rules after; September 1752 runs 1, 2, 14 .. 30. A year outside
// 1..9999 or a month outside 1..12 gives one transfer with tuser set, tlast
// set and zero data. A request runs through the setup steps capture, divide
// by 100, Zeller sum and mod 7, then gives one day result per cycle while the
// output is ready, n results in all (n is 1, 19 or 28 to 31). The next
// request is taken only after the final result of the current one transfers.
module month_calendar_day_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // year_value[13:0], month_value[17:14], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // day_number[4:0], weekday_index[7:5], row_index[10:8], zero pad
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // bad_request[0]
);
    import mcds_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [DAY_W-1:0]   w_day;
    logic [WDAY_W-1:0]  w_wday;
    logic [ROW_W-1:0]   w_row;
    logic               w_bad;

    // controller
    mcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // datapath
    mcds_dp u_dp (
        .i_clk   (i_clk),
        .i_year  (s_axis_tdata[13:0]),
        .i_month (s_axis_tdata[17:14]),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_day   (w_day),
        .o_wday  (w_wday),
        .o_row   (w_row),
        .o_bad   (w_bad)
    );

    // output packing
    assign m_axis_tdata = {5'd0, w_row, w_wday, w_day};
    assign m_axis_tlast = w_stat.last;
    assign m_axis_tuser = w_bad;

endmodule

>>> hdl/mcds_chk.sv
// port-level checker for the month calendar day sequencer, with its bind
module mcds_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic        i_m_tlast,
    input logic        i_m_tuser
);

    // a request is never taken while a day result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_m_tvalid && i_s_tready))
        else $error("request accepted while a result is pending");

    // an error result is a single zeroed final transfer
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser) |-> (i_m_tlast && (i_m_tdata == 16'd0)))
        else $error("error result malformed");

    // a normal day result has day at least 1, weekday and row in range
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser) |->
        ((i_m_tdata[4:0] != 5'd0) && (i_m_tdata[7:5] != 3'd7) &&
         (i_m_tdata[10:8] != 3'd6) && (i_m_tdata[10:8] != 3'd7)))
        else $error("day result out of range");

    // after the final transfer the block waits for a new request
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && i_m_tlast) |=> (!i_m_tvalid && i_s_tready))
        else $error("output active after final transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
        (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast) && $stable(i_m_tuser)))
        else $error("stalled result changed");

endmodule

bind month_calendar_day_sequencer mcds_chk u_mcds_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_m_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
// testbench for the month calendar day sequencer: random requests checked against a calendar predictor
`timescale 1ns / 100ps

module tb;
    import mcds_pkg::*;

    // one day result as it appears on the output: tdata, then tlast, then tuser
    typedef struct packed {
        logic [4:0]        pad;
        logic [ROW_W-1:0]  row;
        logic [WDAY_W-1:0] wday;
        logic [DAY_W-1:0]  day;
        logic              last;
        logic              bad;
    } t_day_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // year_value[13:0], month_value[17:14], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // day_number[4:0], weekday_index[7:5], row_index[10:8], zero pad
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // bad_request[0]

    logic [23:0]  pending_requests[$];
    t_day_result  expected_days[$];
    logic         req_taken = 1'b0;
    int unsigned  burst_left = 0;
    int unsigned  gap_left = 0;
    int unsigned  stall_mode = 0;
    int unsigned  stall_mode_left = 0;
    int unsigned  fail_count = 0;
    int unsigned  requests_taken = 0;
    int unsigned  days_checked = 0;
    int unsigned  bad_seen = 0;
    int unsigned  reform_seen = 0;

    month_calendar_day_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // expected day results of one request, appended to expected_days
    function automatic void predict_month(input logic [YEAR_W-1:0] yr,
                                          input logic [MONTH_W-1:0] mo);
        int unsigned y, q, h, wd, row, day, next_day, month_days;
        bit julian, reform, leap, final_day;
        t_day_result r;
        r = '0;
        if (yr < 1 || yr > 9999 || mo < 1 || mo > 12) begin
            r.last = 1'b1;
            r.bad  = 1'b1;
            expected_days.push_back(r);
            return;
        end
        julian = (yr < 1752) || (yr == 1752 && mo <= 9);
        reform = (yr == 1752 && mo == 9);
        // month length with the leap rule of the calendar in force
        case (mo)
            4, 6, 9, 11: month_days = 30;
            2:           month_days = 28;
            default:     month_days = 31;
        endcase
        if (julian)
            leap = (yr % 4 == 0);
        else
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        if (mo == 2 && leap)
            month_days = 29;
        // zeller weekday of the 1st, jan and feb counted in the previous year
        y = yr;
        q = mo;
        if (mo <= 2) begin
            y = y - 1;
            q = q + 12;
        end
        h = 1 + (13 * (q + 1)) / 5 + y + y / 4;
        if (julian)
            h = h + 5;
        else
            h = h + y / 400 - y / 100;
        h = h % 7;
        wd = (h != 0) ? h - 1 : 6;
        row = 0;
        day = 1;
        final_day = 1'b0;
        while (!final_day) begin
            next_day = day + 1;
            if (reform && day == 2)
                next_day = 14;
            final_day = (next_day > month_days);
            r.day  = day[DAY_W-1:0];
            r.wday = wd[WDAY_W-1:0];
            r.row  = row[ROW_W-1:0];
            r.last = final_day;
            expected_days.push_back(r);
            if (wd == 6) begin
                wd = 0;
                row = row + 1;
            end else begin
                wd = wd + 1;
            end
            day = next_day;
        end
    endfunction

    // requests go on the bus as packed tdata
    task automatic add_request(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo);
        pending_requests.push_back({6'b0, mo, yr});
    endtask

    // sender: bursts of requests with random gaps after each burst
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_requests.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    case ($urandom_range(0, 3))
                        0:       gap_left <= 0;
                        1:       gap_left <= $urandom_range(1, 4);
                        2:       gap_left <= $urandom_range(5, 20);
                        default: gap_left <= $urandom_range(21, 45);
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switching between always ready, coin flip and rare ready
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_mode_left <= $urandom_range(20, 200);
            end else begin
                stall_mode_left <= stall_mode_left - 1;
            end
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // monitor: check each output transfer, then predict on each accepted request
    always @(posedge i_clk) begin
        t_day_result seen, want;
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (expected_days.size() == 0) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: unexpected transfer day=%0d wday=%0d row=%0d last=%0b bad=%0b",
                             $time, seen.day, seen.wday, seen.row, seen.last, seen.bad);
                end else begin
                    want = expected_days.pop_front();
                    days_checked <= days_checked + 1;
                    if (seen.bad)
                        bad_seen <= bad_seen + 1;
                    if (seen != want) begin
                        fail_count <= fail_count + 1;
                        $display("%0t: mismatch expected day=%0d wday=%0d row=%0d last=%0b bad=%0b pad=%0h",
                                 $time, want.day, want.wday, want.row, want.last, want.bad,
                                 want.pad);
                        $display("%0t:          actual   day=%0d wday=%0d row=%0d last=%0b bad=%0b pad=%0h",
                                 $time, seen.day, seen.wday, seen.row, seen.last, seen.bad,
                                 seen.pad);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                requests_taken <= requests_taken + 1;
                if (s_axis_tdata[13:0] == REFORM_YEAR && s_axis_tdata[17:14] == REFORM_MONTH)
                    reform_seen <= reform_seen + 1;
                predict_month(s_axis_tdata[13:0], s_axis_tdata[17:14]);
            end
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int n, pick;
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;

        // field extremes, bad requests and the calendar reform
        add_request(14'd1, 4'd1);
        add_request(14'd9999, 4'd12);
        add_request(14'd0, 4'd5);
        add_request(14'd16383, 4'd15);
        add_request(14'd10000, 4'd3);
        add_request(14'd2024, 4'd0);
        add_request(14'd2024, 4'd13);
        add_request(14'd9998, 4'd15);
        add_request(14'd1752, 4'd9);
        add_request(14'd1752, 4'd8);
        add_request(14'd1752, 4'd10);
        // leap rules on either side of the reform
        add_request(14'd1752, 4'd2);
        add_request(14'd1700, 4'd2);
        add_request(14'd1800, 4'd2);
        add_request(14'd1900, 4'd2);
        add_request(14'd2000, 4'd2);
        add_request(14'd2023, 4'd2);
        add_request(14'd1, 4'd2);
        add_request(14'd9999, 4'd1);
        // remaining months but May, and a month that needs six rows
        add_request(14'd2025, 4'd3);
        add_request(14'd2025, 4'd4);
        add_request(14'd2025, 4'd6);
        add_request(14'd2025, 4'd7);
        add_request(14'd2025, 4'd11);
        add_request(14'd2022, 4'd1);

        // random requests, mostly valid, weighted toward the reform and february
        for (n = 0; n < 350; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                yr = YEAR_W'($urandom);
                mo = MONTH_W'($urandom);
            end else if (pick < 25) begin
                yr = YEAR_W'($urandom_range(1700, 1800));
                mo = MONTH_W'($urandom_range(1, 12));
            end else if (pick < 35) begin
                yr = YEAR_W'($urandom_range(1, 9999));
                mo = MONTH_FEB;
            end else if (pick < 38) begin
                yr = REFORM_YEAR;
                mo = MONTH_W'($urandom_range(8, 10));
            end else begin
                yr = YEAR_W'($urandom_range(1, 9999));
                mo = MONTH_W'($urandom_range(1, 12));
            end
            add_request(yr, mo);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid || expected_days.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d requests, %0d day results checked", requests_taken, days_checked);
        $display("of which %0d error results and %0d reform month requests", bad_seen, reform_seen);
        if (fail_count == 0 && expected_days.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
